>>> design/rsnt_pkg.sv
`timescale 1ns / 1ps
package rsnt_pkg;
  localparam int unsigned ID_W = 32;
  localparam int unsigned TAG_W = 48;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CNT_W = 4;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUCC = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PRED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXISTS = 3'd4;

  localparam logic [0:0] REG_REF_ID = 1'b0;
  localparam logic [0:0] REG_BUCKET = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0] key_id;
    logic [TAG_W-1:0] key_tag;
  } in_word_t;

  typedef struct packed {
    logic hit;
    logic [ID_W-1:0] entry_id;
    logic [TAG_W-1:0] entry_tag;
    logic [CNT_W-1:0] count;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TAG_W-1:0] tag;
  } entry_t;

  function automatic logic in_ring(input logic [ID_W-1:0] a, input logic [ID_W-1:0] m,
                                   input logic [ID_W-1:0] b, input logic closed);
    logic [ID_W-1:0] dm;
    logic [ID_W-1:0] db;
    dm = m - a;
    db = b - a;
    if (dm == '0) return (db == '0) && closed;
    if (dm == db) return closed;
    if (db == '0) return 1'b1;
    return dm < db;
  endfunction
endpackage

>>> design/rsnt_cell.sv
`timescale 1ns / 1ps
module rsnt_cell (
  input  logic clk,
  input  logic shift,
  input  rsnt_pkg::entry_t prev_entry,
  output rsnt_pkg::entry_t entry
);
  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= prev_entry;
    end
  end
endmodule

>>> design/ring_sorted_neighbor_table_unit.sv
`timescale 1ns / 1ps
// The output word is offered after one full rotation of the cell chain, one slot per
// cycle past the head compare. One word is in flight at a time: a new word is taken
// only after the last output word is taken; a stalled output word holds the input off.
// Reset (rst, synchronous): table empty, ref_id = 0, bucket_size = 8.
module ring_sorted_neighbor_table_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rsnt_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsnt_pkg::out_word_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [rsnt_pkg::ID_W-1:0] cfg_data
);
  localparam int unsigned IW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  logic [rsnt_pkg::ID_W-1:0] ref_id;
  logic [rsnt_pkg::CNT_W-1:0] bucket_size;
  logic [IW-1:0] fill, step, n_new, cap;
  rsnt_pkg::in_word_t req;
  rsnt_pkg::entry_t chain [DEPTH];
  rsnt_pkg::entry_t head, next_head, tail_in, carry, best, key_e;
  logic rot, carrying, done, hit, best_ok, rm_found;
  logic valid_slot, last_slot, is_add, live_add, match, ahead, evict;

  assign head = chain[0];
  assign next_head = chain[1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rsnt_pkg::entry_t nb;
    rsnt_pkg::entry_t q;
    if (g == DEPTH - 1) begin : g_tail
      assign nb = tail_in;
    end else begin : g_link
      assign nb = chain[g + 1];
    end
    rsnt_cell u_cell (
      .clk(clk), .shift(rot), .prev_entry(nb), .entry(q)
    );
    assign chain[g] = q;
  end

  always_comb begin
    if (bucket_size == '0) cap = IW'(1);
    else if (32'(bucket_size) > DEPTH) cap = IW'(DEPTH);
    else cap = IW'(bucket_size);
  end

  assign key_e = '{id: req.key_id, tag: req.key_tag};
  assign valid_slot = step < fill;
  assign last_slot = step == fill - IW'(1);
  assign is_add = req.cmd == rsnt_pkg::CMD_ADD;
  assign live_add = is_add && !done && (req.key_id != ref_id);
  assign match = head.id == req.key_id;
  assign ahead = rsnt_pkg::in_ring(ref_id, req.key_id, head.id, 1'b0);
  assign evict = last_slot && (fill >= cap);

  always_comb begin
    tail_in = head;
    case (req.cmd)
      rsnt_pkg::CMD_ADD: begin
        if (valid_slot) begin
          if (carrying) tail_in = carry;
          else if (live_add && (match || ahead)) tail_in = key_e;
        end else if (step == fill) begin
          if (carrying) tail_in = carry;
          else if (live_add && fill < cap) tail_in = key_e;
        end
      end
      rsnt_pkg::CMD_REMOVE: begin
        if (rm_found || (valid_slot && match)) tail_in = next_head;
      end
      default: tail_in = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ref_id <= '0;
      bucket_size <= rsnt_pkg::CNT_W'(8);
      fill <= '0;
      step <= '0;
      carrying <= 1'b0;
      done <= 1'b0;
      hit <= 1'b0;
      best_ok <= 1'b0;
      rm_found <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rsnt_pkg::REG_REF_ID) ref_id <= cfg_data;
        else bucket_size <= cfg_data[rsnt_pkg::CNT_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            step <= '0;
            carrying <= 1'b0;
            done <= 1'b0;
            hit <= 1'b0;
            best_ok <= 1'b0;
            rm_found <= 1'b0;
            best <= '0;
            n_new <= fill;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          case (req.cmd)
            rsnt_pkg::CMD_ADD: begin
              if (valid_slot) begin
                if (carrying) begin
                  carry <= head;
                  if (evict) begin
                    hit <= 1'b1;
                    best <= head;
                    carrying <= 1'b0;
                  end
                end else if (live_add && match) begin
                  done <= 1'b1;
                end else if (live_add && ahead) begin
                  done <= 1'b1;
                  if (evict) begin
                    hit <= 1'b1;
                    best <= head;
                  end else begin
                    carry <= head;
                    carrying <= 1'b1;
                  end
                end
              end else if (step == fill) begin
                if (carrying || (live_add && fill < cap)) begin
                  carrying <= 1'b0;
                  n_new <= fill + IW'(1);
                end
              end
            end
            rsnt_pkg::CMD_REMOVE: begin
              if (valid_slot && !rm_found && match) begin
                rm_found <= 1'b1;
                hit <= 1'b1;
                best <= head;
                n_new <= fill - IW'(1);
              end
            end
            rsnt_pkg::CMD_SUCC: begin
              if (valid_slot && (!best_ok ||
                  rsnt_pkg::in_ring(best.id, req.key_id, head.id, 1'b1))) begin
                best <= head;
                best_ok <= 1'b1;
                hit <= 1'b1;
              end
            end
            rsnt_pkg::CMD_PRED: begin
              if (valid_slot && (!best_ok ||
                  rsnt_pkg::in_ring(best.id, head.id, req.key_id, 1'b0))) begin
                best <= head;
                best_ok <= 1'b1;
                hit <= 1'b1;
              end
            end
            rsnt_pkg::CMD_EXISTS: begin
              if (valid_slot && match && head.tag == req.key_tag) hit <= 1'b1;
            end
            default: ;
          endcase
          if (step == IW'(DEPTH - 1)) begin
            step <= '0;
            state <= S_OUT;
          end else begin
            step <= step + IW'(1);
          end
        end
        S_OUT: begin
          if (out_ready) begin
            fill <= n_new;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rot = state == S_SCAN;

  assign in_ready = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = state == S_OUT;
  assign out_data = '{hit: hit, entry_id: hit ? best.id : '0,
                      entry_tag: hit ? best.tag : '0,
                      count: rsnt_pkg::CNT_W'(n_new)};

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= IW'(DEPTH))
    else $error("fill exceeds depth");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");
`endif
endmodule

>>> sim/tb_ring_sorted_neighbor_table_unit.sv
`timescale 1ns / 1ps
module tb_ring_sorted_neighbor_table_unit;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rsnt_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsnt_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [rsnt_pkg::ID_W-1:0] cfg_data = '0;

  ring_sorted_neighbor_table_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // table shadow
  logic [rsnt_pkg::ID_W-1:0] nb_id[0:8];
  logic [rsnt_pkg::TAG_W-1:0] nb_tag[0:8];
  int unsigned nb_fill = 0;
  logic [rsnt_pkg::ID_W-1:0] own_id = '0;
  logic [3:0] bucket_reg = 4'd8;

  rsnt_pkg::in_word_t pending_words[$];
  rsnt_pkg::out_word_t expected_results[$];
  logic [rsnt_pkg::ID_W-1:0] id_pool[16];
  bit calm = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int unsigned errors = 0;

  function automatic bit ring_between(logic [rsnt_pkg::ID_W-1:0] a,
                                      logic [rsnt_pkg::ID_W-1:0] m,
                                      logic [rsnt_pkg::ID_W-1:0] b, bit closed);
    logic [rsnt_pkg::ID_W-1:0] dm;
    logic [rsnt_pkg::ID_W-1:0] db;
    dm = m - a;
    db = b - a;
    if (dm == 0) return (db == 0) && closed;
    if (dm == db) return closed;
    if (db == 0) return 1'b1;
    return dm < db;
  endfunction

  function automatic int unsigned table_cap();
    int unsigned c;
    c = bucket_reg;
    if (c == 0) c = 1;
    if (c > 8) c = 8;
    return c;
  endfunction

  function automatic rsnt_pkg::out_word_t table_apply(rsnt_pkg::in_word_t w);
    rsnt_pkg::out_word_t r;
    int unsigned n;
    int unsigned best;
    bit placed;
    bit take;
    r = '0;
    n = nb_fill;
    placed = 0;
    case (w.cmd)
      rsnt_pkg::CMD_ADD: begin
        if (w.key_id != own_id) begin
          for (int i = 0; i < n; i++) begin
            if (nb_id[i] == w.key_id) begin
              nb_tag[i] = w.key_tag;
              placed = 1;
              break;
            end
            if (ring_between(own_id, w.key_id, nb_id[i], 0)) begin
              for (int k = n; k > i; k--) begin
                nb_id[k] = nb_id[k-1];
                nb_tag[k] = nb_tag[k-1];
              end
              nb_id[i] = w.key_id;
              nb_tag[i] = w.key_tag;
              placed = 1;
              if (n + 1 > table_cap()) begin
                r.hit = 1'b1;
                r.entry_id = nb_id[n];
                r.entry_tag = nb_tag[n];
              end else begin
                n++;
              end
              break;
            end
          end
          if (!placed && n < table_cap()) begin
            nb_id[n] = w.key_id;
            nb_tag[n] = w.key_tag;
            n++;
          end
        end
      end
      rsnt_pkg::CMD_REMOVE: begin
        for (int i = 0; i < n; i++) begin
          if (nb_id[i] == w.key_id) begin
            r.hit = 1'b1;
            r.entry_id = nb_id[i];
            r.entry_tag = nb_tag[i];
            for (int k = i; k + 1 < n; k++) begin
              nb_id[k] = nb_id[k+1];
              nb_tag[k] = nb_tag[k+1];
            end
            n--;
            break;
          end
        end
      end
      rsnt_pkg::CMD_SUCC, rsnt_pkg::CMD_PRED: begin
        if (n > 0) begin
          best = 0;
          for (int i = 0; i < n; i++) begin
            if (w.cmd == rsnt_pkg::CMD_SUCC)
              take = ring_between(nb_id[best], w.key_id, nb_id[i], 1);
            else
              take = ring_between(nb_id[best], nb_id[i], w.key_id, 0);
            if (take) best = i;
          end
          r.hit = 1'b1;
          r.entry_id = nb_id[best];
          r.entry_tag = nb_tag[best];
        end
      end
      rsnt_pkg::CMD_EXISTS: begin
        for (int i = 0; i < n; i++) begin
          if (nb_id[i] == w.key_id && nb_tag[i] == w.key_tag) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    nb_fill = n;
    r.count = n[3:0];
    return r;
  endfunction

  function automatic logic [rsnt_pkg::TAG_W-1:0] tag_for(logic [rsnt_pkg::ID_W-1:0] id);
    return {id[15:0], id} ^ 48'h5a5a_c3c3_0f0f;
  endfunction

  function automatic rsnt_pkg::in_word_t mk(logic [rsnt_pkg::CMD_W-1:0] c,
                                            logic [rsnt_pkg::ID_W-1:0] id,
                                            logic [rsnt_pkg::TAG_W-1:0] tg);
    rsnt_pkg::in_word_t w;
    w.cmd = c;
    w.key_id = id;
    w.key_tag = tg;
    return w;
  endfunction

  function automatic void queue_word(rsnt_pkg::in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic rsnt_pkg::in_word_t rand_word();
    rsnt_pkg::in_word_t w;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) w.cmd = rsnt_pkg::CMD_ADD;
    else if (p < 55) w.cmd = rsnt_pkg::CMD_REMOVE;
    else if (p < 70) w.cmd = rsnt_pkg::CMD_SUCC;
    else if (p < 85) w.cmd = rsnt_pkg::CMD_PRED;
    else if (p < 95) w.cmd = rsnt_pkg::CMD_EXISTS;
    else w.cmd = rsnt_pkg::CMD_W'($urandom_range(5, 7));
    p = $urandom_range(0, 99);
    if (p < 78) w.key_id = id_pool[$urandom_range(0, 15)];
    else if (p < 83) w.key_id = own_id;
    else w.key_id = $urandom;
    if ($urandom_range(0, 99) < 70) w.key_tag = tag_for(w.key_id);
    else w.key_tag = rsnt_pkg::TAG_W'({$urandom, $urandom});
    return w;
  endfunction

  task automatic write_reg(logic idx, logic [rsnt_pkg::ID_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rsnt_pkg::REG_REF_ID) own_id = val;
    else bucket_reg = val[3:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(logic [rsnt_pkg::ID_W-1:0] ref_val, logic [3:0] bucket);
    write_reg(rsnt_pkg::REG_REF_ID, ref_val);
    write_reg(rsnt_pkg::REG_BUCKET, ($urandom & ~32'hF) | {28'd0, bucket});
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = ref_val + 32'd1;
    id_pool[3] = ref_val - 32'd1;
    for (int i = 4; i < 16; i++) id_pool[i] = $urandom;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_words(int unsigned n);
    for (int i = 0; i < n; i++) queue_word(rand_word());
  endtask

  // driver
  int unsigned src_idle = 0;
  always @(posedge clk) begin
    logic nv;
    rsnt_pkg::in_word_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), table_apply(in_data));
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_idle > 0) begin
          src_idle--;
        end else if (pending_words.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            src_idle = $urandom_range(1, 8);
          end else begin
            nd = pending_words.pop_front();
            nv = 1'b1;
          end
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // monitor
  int unsigned snk_idle = 0;
  always @(posedge clk) begin
    rsnt_pkg::out_word_t e;
    logic nr;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.hit !== e.hit) begin
          $display("%0t hit exp %h got %h", $time, e.hit, out_data.hit);
          errors++;
        end
        if (out_data.entry_id !== e.entry_id) begin
          $display("%0t entry_id exp %h got %h", $time, e.entry_id, out_data.entry_id);
          errors++;
        end
        if (out_data.entry_tag !== e.entry_tag) begin
          $display("%0t entry_tag exp %h got %h", $time, e.entry_tag, out_data.entry_tag);
          errors++;
        end
        if (out_data.count !== e.count) begin
          $display("%0t count exp %h got %h", $time, e.count, out_data.count);
          errors++;
        end
      end
    end
    nr = 1'b1;
    if (hold_req && !hold_done) begin
      snk_idle = 400;
      hold_done = 1;
    end
    if (snk_idle > 0) begin
      snk_idle--;
      nr = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      snk_idle = $urandom_range(1, 8);
      nr = 1'b0;
    end
    out_ready <= nr;
  end

  // watchdog
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= 5000) begin
      $display("[ring_sorted_neighbor_table_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_phase(32'h8000_0000, 4'd4);
    queue_word(mk(rsnt_pkg::CMD_SUCC, 32'h5, '0));
    queue_word(mk(rsnt_pkg::CMD_PRED, 32'h5, '0));
    queue_word(mk(rsnt_pkg::CMD_REMOVE, 32'h1234, '0));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h8000_0000, 48'h1));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h0, '1));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'hffff_ffff, '0));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h8000_0001, 48'h2));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h7fff_ffff, 48'h3));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h9000_0000, 48'h4));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h7000_0000, 48'h5));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'hffff_ffff, 48'h123));
    queue_word(mk(rsnt_pkg::CMD_EXISTS, 32'hffff_ffff, 48'h123));
    queue_word(mk(rsnt_pkg::CMD_EXISTS, 32'hffff_ffff, 48'h0));
    queue_word(mk(rsnt_pkg::CMD_SUCC, 32'h8500_0000, '0));
    queue_word(mk(rsnt_pkg::CMD_PRED, 32'h8500_0000, '0));
    queue_word(mk(rsnt_pkg::CMD_SUCC, 32'h9000_0000, '0));
    queue_word(mk(rsnt_pkg::CMD_PRED, 32'h8000_0001, '0));
    queue_word(mk(rsnt_pkg::CMD_REMOVE, 32'h0, '0));
    queue_word(mk(rsnt_pkg::CMD_ADD, 32'h8000_0000, '1));
    queue_word(mk(3'd5, '1, '1));
    queue_word(mk(3'd6, 32'h8000_0001, '0));
    queue_word(mk(3'd7, 32'h0, '1));
    drain();

    set_phase(32'hffff_ffff, 4'd1);
    random_words(80);
    drain();

    set_phase($urandom, 4'd8);
    hold_req = 1;
    random_words(150);
    drain();

    // shrink capacity below the current fill
    write_reg(rsnt_pkg::REG_BUCKET, 32'd2);
    random_words(60);
    drain();

    set_phase($urandom, 4'd0);
    random_words(70);
    drain();

    set_phase(32'h0, 4'd15);
    random_words(100);
    drain();

    set_phase($urandom, 4'd3);
    calm = 1;
    random_words(170);
    drain();

    if (errors == 0)
      $display("[ring_sorted_neighbor_table_unit] OK");
    else
      $display("[ring_sorted_neighbor_table_unit] ERROR");
    $finish;
  end
endmodule
